// ===== sv/lfs_pkg.sv =====
// Shared constants, types and tables for the line-follow steering sequencer.
package lfs_pkg;

	localparam int SAMPLE_BITS    = 12;
	localparam int COUNT_BITS     = 24;
	localparam int BEACON_BITS    = 8;
	localparam int SERVO_BITS     = 12;
	localparam int MOTOR_BITS     = 10;
	localparam int PHASE_BITS     = 3;
	localparam int LINE_SENSORS   = 7;

	localparam int IN_TDATA_BITS  = 104;
	localparam int OUT_TDATA_BITS = 32;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 24;

	// steering divide: |gain * weight| <= 1023 * 18, divisor 9 * count <= 63
	localparam int PROD_BITS      = 16;
	localparam int DVD_BITS       = 15;
	localparam int DEN_BITS       = 6;
	localparam int DIV_CNT_BITS   = $clog2(DVD_BITS);
	localparam int WEIGHT_BITS    = 6;
	localparam int HIT_CNT_BITS   = 3;

	localparam logic [MOTOR_BITS-1:0]  SWERVE_DROP = 10'd50;
	localparam logic [BEACON_BITS-1:0] GO_CODE     = 8'd2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_THRESHOLD  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_OBSTACLE  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SECOND_OBSTACLE = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CRUISE_POWER    = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SWERVE_TICKS    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SERVO_CENTER    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SERVO_GAIN      = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SWERVE_OFFSET   = 3'd7;

	// reset values
	localparam logic [SAMPLE_BITS-1:0] RST_LINE_THRESHOLD  = 12'd330;
	localparam logic [SAMPLE_BITS-1:0] RST_FIRST_OBSTACLE  = 12'd1500;
	localparam logic [SAMPLE_BITS-1:0] RST_SECOND_OBSTACLE = 12'd1200;
	localparam logic [MOTOR_BITS-1:0]  RST_CRUISE_POWER    = 10'd800;
	localparam logic [COUNT_BITS-1:0]  RST_SWERVE_TICKS    = 24'd200000;
	localparam logic [SERVO_BITS-1:0]  RST_SERVO_CENTER    = 12'd2650;
	localparam logic [MOTOR_BITS-1:0]  RST_SERVO_GAIN      = 10'd750;
	localparam logic [MOTOR_BITS-1:0]  RST_SWERVE_OFFSET   = 10'd690;

	// phase codes
	localparam logic [PHASE_BITS-1:0] PH_WAIT       = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_FOLLOW_A   = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_SWERVE_OUT = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_FOLLOW_B   = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_SWERVE_BK  = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_FOLLOW_C   = 3'd5;

	// sensor weights, outer left first
	localparam logic signed [4:0] LINE_WEIGHT [LINE_SENSORS] =
		'{5'sd9, 5'sd6, 5'sd3, 5'sd0, -5'sd3, -5'sd6, -5'sd9};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_WRITE
	} seq_state_t;

endpackage

// ===== sv/lfs_div.sv =====
// Iterative floor divider, one quotient bit per cycle.
module lfs_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [lfs_pkg::PROD_BITS-1:0]    num,
	input  logic        [lfs_pkg::DEN_BITS-1:0]     den,
	output logic                                    done,
	output logic signed [lfs_pkg::PROD_BITS-1:0]    quo
);

	localparam logic [lfs_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
		lfs_pkg::DIV_CNT_BITS'(lfs_pkg::DVD_BITS - 1);

	logic                                busy_q;
	logic                                done_q;
	logic [lfs_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic                                neg_q;
	logic [lfs_pkg::DVD_BITS-1:0]        dvd_q;
	logic [lfs_pkg::DEN_BITS-1:0]        den_q;
	logic [lfs_pkg::DEN_BITS-1:0]        rem_q;

	logic [lfs_pkg::PROD_BITS-1:0]       num_abs;
	logic [lfs_pkg::DEN_BITS:0]          trial;
	logic                                fits;
	logic [lfs_pkg::DEN_BITS:0]          trial_sub;
	logic [lfs_pkg::PROD_BITS-1:0]       quo_mag;

	assign num_abs   = num[lfs_pkg::PROD_BITS-1] ? (~num + 1'b1) : num;
	assign trial     = {rem_q, dvd_q[lfs_pkg::DVD_BITS-1]};
	assign fits      = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[lfs_pkg::PROD_BITS-1];
			dvd_q <= num_abs[lfs_pkg::DVD_BITS-1:0];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[lfs_pkg::DEN_BITS-1:0] : trial[lfs_pkg::DEN_BITS-1:0];
			dvd_q <= {dvd_q[lfs_pkg::DVD_BITS-2:0], fits};
		end
	end

	// floor of a negative quotient: -q when exact, -q-1 (= ~q) otherwise
	assign quo_mag = {1'b0, dvd_q};
	always_comb begin
		if (!neg_q)
			quo = quo_mag;
		else if (rem_q != '0)
			quo = ~quo_mag;
		else
			quo = ~quo_mag + 1'b1;
	end

	assign done = done_q;

endmodule

// ===== sv/line_follow_steering_sequencer.sv =====
// Line-follow steering sequencer: sensor weighting, phase sequencer, servo and motor duty.
// A following tick with line hits passes through the prep, divide and write states; every
// other tick goes from prep straight to write. The steering divide runs on one shared
// restoring divider, and a new beat is taken only once the last result is loaded.
// The result register frees the input side while a beat waits on the output.
// arst_n clears registers to defaults, phase to wait, held servo to the center default.
module line_follow_steering_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// left_outer, left_middle, left_inner, centre_line, right_inner, right_middle,
	// right_outer, front_distance, beacon_code
	input  logic [lfs_pkg::IN_TDATA_BITS-1:0]    s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// servo_duty, motor_duty, phase_now, zero fill
	output logic [lfs_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
	input  logic                                 cfg_wr_en,
	input  logic [lfs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [lfs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int SB = lfs_pkg::SAMPLE_BITS;
	localparam int FRONT_LSB  = lfs_pkg::LINE_SENSORS * SB;
	localparam int BEACON_LSB = FRONT_LSB + SB;
	localparam logic [lfs_pkg::SERVO_BITS-1:0] SERVO_MAX = '1;

	// configuration registers
	logic [SB-1:0]                       thr_q;
	logic [SB-1:0]                       obst1_lvl_q;
	logic [SB-1:0]                       obst2_lvl_q;
	logic [lfs_pkg::MOTOR_BITS-1:0]      cruise_q;
	logic [lfs_pkg::COUNT_BITS-1:0]      ticks_q;
	logic [lfs_pkg::SERVO_BITS-1:0]      center_q;
	logic [lfs_pkg::MOTOR_BITS-1:0]      gain_q;
	logic [lfs_pkg::MOTOR_BITS-1:0]      offset_q;

	// sequencer and block state
	lfs_pkg::seq_state_t                 state_q, state_d;
	logic [lfs_pkg::PHASE_BITS-1:0]      phase_q;
	logic [lfs_pkg::COUNT_BITS-1:0]      swerve_cnt_q;
	logic [lfs_pkg::SERVO_BITS-1:0]      held_servo_q;
	logic                                m_tvalid_q;
	logic [lfs_pkg::OUT_TDATA_BITS-1:0]  m_tdata_q;

	// captured tick
	logic [lfs_pkg::LINE_SENSORS-1:0]    hits_q;
	logic                                obst1_q;
	logic                                obst2_q;
	logic                                go_q;

	logic [SB-1:0]                       sample [lfs_pkg::LINE_SENSORS];
	logic                                in_beat;
	logic                                follow;
	logic                                div_start;
	logic                                div_done;
	logic                                load_out;
	logic signed [lfs_pkg::WEIGHT_BITS-1:0] weight;
	logic [lfs_pkg::HIT_CNT_BITS-1:0]    hit_cnt;
	logic [lfs_pkg::DEN_BITS-1:0]        den;
	logic signed [lfs_pkg::PROD_BITS:0]  prod;
	logic signed [lfs_pkg::PROD_BITS-1:0] div_quo;
	logic signed [lfs_pkg::PROD_BITS:0]  steer_sum;
	logic [lfs_pkg::SERVO_BITS-1:0]      steer_servo;
	logic [lfs_pkg::SERVO_BITS:0]        out_sum;
	logic [lfs_pkg::SERVO_BITS-1:0]      swerve_out_servo;
	logic [lfs_pkg::SERVO_BITS-1:0]      swerve_bk_servo;
	logic [lfs_pkg::MOTOR_BITS-1:0]      swerve_motor;
	logic [lfs_pkg::COUNT_BITS-1:0]      swerve_len;
	logic [lfs_pkg::COUNT_BITS:0]        cnt_inc;
	logic                                swerve_end;
	logic [lfs_pkg::SERVO_BITS-1:0]      servo_res;
	logic [lfs_pkg::MOTOR_BITS-1:0]      motor_res;
	logic [lfs_pkg::PHASE_BITS-1:0]      phase_d;
	logic [lfs_pkg::COUNT_BITS-1:0]      swerve_cnt_d;
	logic                                held_upd;

	for (genvar k = 0; k < lfs_pkg::LINE_SENSORS; k++) begin : g_sample
		assign sample[k] = s_tdata[k*SB +: SB];
	end

	assign in_beat  = s_tvalid && s_tready;
	assign follow   = (phase_q == lfs_pkg::PH_FOLLOW_A) || (phase_q == lfs_pkg::PH_FOLLOW_B) ||
	                  (phase_q == lfs_pkg::PH_FOLLOW_C);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= lfs_pkg::RST_LINE_THRESHOLD;
			obst1_lvl_q <= lfs_pkg::RST_FIRST_OBSTACLE;
			obst2_lvl_q <= lfs_pkg::RST_SECOND_OBSTACLE;
			cruise_q    <= lfs_pkg::RST_CRUISE_POWER;
			ticks_q     <= lfs_pkg::RST_SWERVE_TICKS;
			center_q    <= lfs_pkg::RST_SERVO_CENTER;
			gain_q      <= lfs_pkg::RST_SERVO_GAIN;
			offset_q    <= lfs_pkg::RST_SWERVE_OFFSET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				lfs_pkg::REG_LINE_THRESHOLD:  thr_q       <= cfg_data[SB-1:0];
				lfs_pkg::REG_FIRST_OBSTACLE:  obst1_lvl_q <= cfg_data[SB-1:0];
				lfs_pkg::REG_SECOND_OBSTACLE: obst2_lvl_q <= cfg_data[SB-1:0];
				lfs_pkg::REG_CRUISE_POWER:    cruise_q    <= cfg_data[lfs_pkg::MOTOR_BITS-1:0];
				lfs_pkg::REG_SWERVE_TICKS:    ticks_q     <= cfg_data[lfs_pkg::COUNT_BITS-1:0];
				lfs_pkg::REG_SERVO_CENTER:    center_q    <= cfg_data[lfs_pkg::SERVO_BITS-1:0];
				lfs_pkg::REG_SERVO_GAIN:      gain_q      <= cfg_data[lfs_pkg::MOTOR_BITS-1:0];
				lfs_pkg::REG_SWERVE_OFFSET:   offset_q    <= cfg_data[lfs_pkg::MOTOR_BITS-1:0];
			endcase
		end
	end

	// capture the compare results of the tick
	always_ff @(posedge clk) begin
		if (in_beat) begin
			for (int k = 0; k < lfs_pkg::LINE_SENSORS; k++)
				hits_q[k] <= sample[k] < thr_q;
			obst1_q <= s_tdata[FRONT_LSB +: SB] > obst1_lvl_q;
			obst2_q <= s_tdata[FRONT_LSB +: SB] > obst2_lvl_q;
			go_q    <= s_tdata[BEACON_LSB +: lfs_pkg::BEACON_BITS] == lfs_pkg::GO_CODE;
		end
	end

	// weight sum and hit count
	always_comb begin
		weight  = '0;
		hit_cnt = '0;
		for (int k = 0; k < lfs_pkg::LINE_SENSORS; k++) begin
			if (hits_q[k]) begin
				weight  = weight + lfs_pkg::WEIGHT_BITS'(lfs_pkg::LINE_WEIGHT[k]);
				hit_cnt = hit_cnt + 1'b1;
			end
		end
	end

	assign den  = {hit_cnt, 3'b000} + {3'b000, hit_cnt};
	assign prod = $signed({1'b0, gain_q}) * weight;

	lfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[lfs_pkg::PROD_BITS-1:0]),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lfs_pkg::ST_IDLE:  if (s_tvalid) state_d = lfs_pkg::ST_PREP;
			lfs_pkg::ST_PREP:  state_d = div_start ? lfs_pkg::ST_DIV : lfs_pkg::ST_WRITE;
			lfs_pkg::ST_DIV:   if (div_done) state_d = lfs_pkg::ST_WRITE;
			lfs_pkg::ST_WRITE: if (load_out) state_d = lfs_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			lfs_pkg::ST_IDLE:  s_tready  = 1'b1;
			lfs_pkg::ST_PREP:  div_start = follow && (hit_cnt != '0);
			lfs_pkg::ST_DIV:   ;
			lfs_pkg::ST_WRITE: load_out  = !m_tvalid_q || m_tready;
		endcase
	end

	// servo and motor values
	assign steer_sum = $signed({5'b0, center_q}) + (lfs_pkg::PROD_BITS+1)'(div_quo);
	always_comb begin
		if (steer_sum < 0)
			steer_servo = '0;
		else if (steer_sum > $signed({5'b0, SERVO_MAX}))
			steer_servo = SERVO_MAX;
		else
			steer_servo = steer_sum[lfs_pkg::SERVO_BITS-1:0];
	end

	assign out_sum          = {1'b0, center_q} + {3'b000, offset_q};
	assign swerve_out_servo = out_sum[lfs_pkg::SERVO_BITS] ? SERVO_MAX
	                                                       : out_sum[lfs_pkg::SERVO_BITS-1:0];
	assign swerve_bk_servo  = (center_q < {2'b00, offset_q}) ? '0
	                                                          : center_q - {2'b00, offset_q};
	assign swerve_motor     = (cruise_q > lfs_pkg::SWERVE_DROP) ? cruise_q - lfs_pkg::SWERVE_DROP
	                                                            : '0;

	// a swerve length of zero acts as one
	assign swerve_len = (ticks_q == '0) ? lfs_pkg::COUNT_BITS'(1) : ticks_q;
	assign cnt_inc    = {1'b0, swerve_cnt_q} + 1'b1;
	assign swerve_end = cnt_inc >= {1'b0, swerve_len};

	always_comb begin
		servo_res    = held_servo_q;
		motor_res    = '0;
		phase_d      = phase_q;
		swerve_cnt_d = swerve_cnt_q;
		held_upd     = 1'b0;
		case (phase_q) inside
			lfs_pkg::PH_FOLLOW_A, lfs_pkg::PH_FOLLOW_B, lfs_pkg::PH_FOLLOW_C: begin
				motor_res = cruise_q;
				if (hits_q != '0) begin
					servo_res = steer_servo;
					held_upd  = 1'b1;
				end
				if (phase_q == lfs_pkg::PH_FOLLOW_A && obst1_q)
					phase_d = lfs_pkg::PH_SWERVE_OUT;
				if (phase_q == lfs_pkg::PH_FOLLOW_B && obst2_q)
					phase_d = lfs_pkg::PH_SWERVE_BK;
			end
			lfs_pkg::PH_SWERVE_OUT, lfs_pkg::PH_SWERVE_BK: begin
				servo_res = (phase_q == lfs_pkg::PH_SWERVE_OUT) ? swerve_out_servo : swerve_bk_servo;
				motor_res = swerve_motor;
				if (swerve_end) begin
					swerve_cnt_d = '0;
					phase_d      = (phase_q == lfs_pkg::PH_SWERVE_OUT) ? lfs_pkg::PH_FOLLOW_B
					                                                  : lfs_pkg::PH_FOLLOW_C;
				end else begin
					swerve_cnt_d = cnt_inc[lfs_pkg::COUNT_BITS-1:0];
				end
			end
			default: begin
				if (go_q)
					phase_d = lfs_pkg::PH_FOLLOW_A;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lfs_pkg::ST_IDLE;
			phase_q      <= lfs_pkg::PH_WAIT;
			swerve_cnt_q <= '0;
			held_servo_q <= lfs_pkg::RST_SERVO_CENTER;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				phase_q      <= phase_d;
				swerve_cnt_q <= swerve_cnt_d;
				if (held_upd)
					held_servo_q <= servo_res;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk) begin
		if (load_out)
			m_tdata_q <= {7'b0, phase_q, motor_res, servo_res};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
